FILE: hw/rtl/clbm_pkg.sv
// types and constants shared by the channel link backoff monitor
// no dependencies; used by every module of the block
package clbm_pkg;

   localparam int CMD_W     = 3;
   localparam int CHAN_W    = 4;
   localparam int LINK_W    = 3;
   localparam int TIME_W    = 32;
   localparam int STATUS_W  = 3;
   localparam int BACKOFF_W = 12;
   localparam int CSR_IDX_W = 2;

   localparam logic [CMD_W-1:0] CMD_INSTALL = 3'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_OBSERVE = 3'd2;
   localparam logic [CMD_W-1:0] CMD_STOP    = 3'd3;

   localparam logic [LINK_W-1:0] LS_PLAYING    = 3'd0;
   localparam logic [LINK_W-1:0] LS_CONNECTING = 3'd1;
   localparam logic [LINK_W-1:0] LS_NOSIGNAL   = 3'd2;
   localparam logic [LINK_W-1:0] LS_FAIL       = 3'd3;

   localparam logic [STATUS_W-1:0] ST_EMPTY      = 3'd0;
   localparam logic [STATUS_W-1:0] ST_BOUND      = 3'd1;
   localparam logic [STATUS_W-1:0] ST_CONNECTING = 3'd2;
   localparam logic [STATUS_W-1:0] ST_ONLINE     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOSIGNAL   = 3'd4;
   localparam logic [STATUS_W-1:0] ST_FAIL       = 3'd5;
   localparam logic [STATUS_W-1:0] ST_DISABLED   = 3'd6;

   localparam logic [CSR_IDX_W-1:0] CSR_BACKOFF_BASE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BACKOFF_MAX  = 2'd1;

   localparam logic [BACKOFF_W-1:0] DEFAULT_BASE = 12'd5;
   localparam logic [BACKOFF_W-1:0] DEFAULT_MAX  = 12'd30;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [CHAN_W-1:0] channel;
      logic              enable;
      logic [LINK_W-1:0] link_state;
      logic [TIME_W-1:0] now_seconds;
   } req_type;

   typedef struct packed {
      logic [CHAN_W-1:0]   out_channel;
      logic [STATUS_W-1:0] status;
      logic                notify_online;
      logic                notify_offline;
      logic                restart_request;
      logic                error;
   } rsp_type;

   typedef struct packed {
      logic                 used;
      logic [STATUS_W-1:0]  status;
      logic [BACKOFF_W-1:0] backoff;
      logic [TIME_W-1:0]    retry_time;
      logic                 announced;
   } slot_type;

   typedef enum logic {
      CTL_IDLE,
      CTL_EXEC
   } ctl_state_type;

endpackage

FILE: hw/rtl/clbm_slot_ram.sv
// per-channel slot memory, one read and one write port, registered read data
// depends on clbm_pkg; per-entry valid bits make unwritten entries read as zero
module clbm_slot_ram #(
   parameter int DEPTH = 16,
   parameter int IDX_W = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                rd_en,
   input  logic [IDX_W-1:0]    rd_idx,
   output clbm_pkg::slot_type  rd_data,
   input  logic                wr_en,
   input  logic [IDX_W-1:0]    wr_idx,
   input  clbm_pkg::slot_type  wr_data
);

   clbm_pkg::slot_type mem [DEPTH];
   logic [DEPTH-1:0]   vld_ff;
   logic [DEPTH-1:0]   vld_in;
   clbm_pkg::slot_type rd_ff;
   logic               rd_vld_ff;

   always_comb begin
      vld_in = vld_ff;
      if (wr_en) begin
         vld_in[wr_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ff     <= mem[rd_idx];
         rd_vld_ff <= vld_ff[rd_idx];
      end
   end

   assign rd_data = rd_vld_ff ? rd_ff : '0;

endmodule

FILE: hw/rtl/clbm_update.sv
// next-slot and result logic for one command applied to one slot
// depends on clbm_pkg; purely combinational
module clbm_update (
   input  clbm_pkg::req_type                     req,
   input  logic                                  chan_valid,
   input  clbm_pkg::slot_type                    slot_rd,
   input  logic [clbm_pkg::BACKOFF_W-1:0]        base,
   input  logic [clbm_pkg::BACKOFF_W-1:0]        max_delay,
   output clbm_pkg::slot_type                    slot_wr,
   output clbm_pkg::rsp_type                     rsp
);

   logic                             used;
   logic [clbm_pkg::TIME_W:0]        retry_sum;
   logic [clbm_pkg::BACKOFF_W:0]     doubled;
   logic                             n_on;
   logic                             n_off;
   logic                             restart;
   logic                             err;

   assign used      = chan_valid && slot_rd.used;
   assign retry_sum = {1'b0, req.now_seconds}
                    + {{(clbm_pkg::TIME_W + 1 - clbm_pkg::BACKOFF_W){1'b0}}, slot_rd.backoff};
   assign doubled   = {slot_rd.backoff, 1'b0};

   always_comb begin
      slot_wr = slot_rd;
      n_on    = 1'b0;
      n_off   = 1'b0;
      restart = 1'b0;
      err     = 1'b0;
      case (req.cmd)
         clbm_pkg::CMD_INSTALL: begin
            if (chan_valid) begin
               slot_wr.used       = 1'b1;
               slot_wr.status     = req.enable ? clbm_pkg::ST_BOUND : clbm_pkg::ST_DISABLED;
               slot_wr.backoff    = base;
               slot_wr.retry_time = '0;
               slot_wr.announced  = 1'b0;
            end
         end
         clbm_pkg::CMD_REMOVE: begin
            if (!used) begin
               err = 1'b1;
            end else begin
               n_off   = slot_rd.announced;
               slot_wr = '0;
            end
         end
         clbm_pkg::CMD_OBSERVE: begin
            if (used && slot_rd.status != clbm_pkg::ST_DISABLED) begin
               case (req.link_state)
                  clbm_pkg::LS_PLAYING: begin
                     slot_wr.status  = clbm_pkg::ST_ONLINE;
                     slot_wr.backoff = base;
                     if (!slot_rd.announced) begin
                        slot_wr.announced = 1'b1;
                        n_on              = 1'b1;
                     end
                  end
                  clbm_pkg::LS_CONNECTING: begin
                     slot_wr.status = clbm_pkg::ST_CONNECTING;
                  end
                  clbm_pkg::LS_NOSIGNAL, clbm_pkg::LS_FAIL: begin
                     slot_wr.status = (req.link_state == clbm_pkg::LS_NOSIGNAL)
                                    ? clbm_pkg::ST_NOSIGNAL : clbm_pkg::ST_FAIL;
                     if (slot_rd.announced) begin
                        slot_wr.announced = 1'b0;
                        n_off             = 1'b1;
                     end
                     if (req.now_seconds >= slot_rd.retry_time) begin
                        restart = 1'b1;
                        // saturate the retry time on overflow
                        slot_wr.retry_time = retry_sum[clbm_pkg::TIME_W]
                                           ? '1 : retry_sum[clbm_pkg::TIME_W-1:0];
                        slot_wr.backoff = (doubled > {1'b0, max_delay})
                                        ? max_delay : doubled[clbm_pkg::BACKOFF_W-1:0];
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         clbm_pkg::CMD_STOP: begin
            if (used) begin
               slot_wr.status = clbm_pkg::ST_BOUND;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp                 = '0;
      rsp.out_channel     = req.channel;
      rsp.status          = (chan_valid && slot_wr.used) ? slot_wr.status : clbm_pkg::ST_EMPTY;
      rsp.notify_online   = n_on;
      rsp.notify_offline  = n_off;
      rsp.restart_request = restart;
      rsp.error           = err;
   end

endmodule

FILE: hw/rtl/channel_link_backoff_monitor.sv
// top level of the channel link backoff monitor: control, config registers
// depends on clbm_pkg, clbm_slot_ram and clbm_update
//
//   port group   dir   handshake            contents
//   req_*        in    req_valid/req_ready  clbm_pkg::req_type transaction
//   rsp_*        out   rsp_valid/rsp_ready  clbm_pkg::rsp_type transaction
//   csr_*        in    csr_wr_en            register index and 12-bit data
//
// in each transaction the slot memory read issued at accept is registered in the slot memory,
// then the updated slot is written back and the result registered.
// one transaction is in flight at a time; a waiting result does not block accept.
// a stalled result holds the block in its update state until rsp_ready.
// reset is synchronous; valid bits clear the whole slot table at once.
module channel_link_backoff_monitor #(
   parameter int CHANNELS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  clbm_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output clbm_pkg::rsp_type                 rsp_data,
   input  logic                              csr_wr_en,
   input  logic [clbm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [clbm_pkg::BACKOFF_W-1:0]    csr_wdata
);

   localparam int IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CHEXT_W = 9;

   clbm_pkg::ctl_state_type           state_ff, state_in;
   clbm_pkg::req_type                 req_ff;
   logic                              chan_valid_ff;
   logic                              rsp_valid_ff, rsp_valid_in;
   clbm_pkg::rsp_type                 rsp_data_ff;
   logic [clbm_pkg::BACKOFF_W-1:0]    base_ff, max_ff;
   logic [clbm_pkg::BACKOFF_W-1:0]    base_eff, max_eff;
   logic [CHEXT_W-1:0]                chan_ext, chan_ext_q;
   logic                              accept;
   logic                              exec_done;
   clbm_pkg::slot_type                slot_rd, slot_wr;
   clbm_pkg::rsp_type                 rsp_next;

   assign chan_ext   = {{(CHEXT_W - clbm_pkg::CHAN_W){1'b0}}, req_data.channel};
   assign chan_ext_q = {{(CHEXT_W - clbm_pkg::CHAN_W){1'b0}}, req_ff.channel};
   assign req_ready  = (state_ff == clbm_pkg::CTL_IDLE);
   assign accept     = req_valid && req_ready;
   assign exec_done  = (state_ff == clbm_pkg::CTL_EXEC) && (!rsp_valid_ff || rsp_ready);

   // a zero register falls back to its default
   assign base_eff = (base_ff == '0) ? clbm_pkg::DEFAULT_BASE : base_ff;
   assign max_eff  = (max_ff == '0) ? clbm_pkg::DEFAULT_MAX : max_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= clbm_pkg::DEFAULT_BASE;
         max_ff  <= clbm_pkg::DEFAULT_MAX;
      end else if (csr_wr_en) begin
         if (csr_index == clbm_pkg::CSR_BACKOFF_BASE) begin
            base_ff <= csr_wdata;
         end
         if (csr_index == clbm_pkg::CSR_BACKOFF_MAX) begin
            max_ff <= csr_wdata;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         clbm_pkg::CTL_IDLE: begin
            if (accept) begin
               state_in = clbm_pkg::CTL_EXEC;
            end
         end
         clbm_pkg::CTL_EXEC: begin
            if (exec_done) begin
               state_in     = clbm_pkg::CTL_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = clbm_pkg::CTL_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= clbm_pkg::CTL_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff        <= req_data;
         chan_valid_ff <= (chan_ext < CHEXT_W'(CHANNELS));
      end
      if (exec_done) begin
         rsp_data_ff <= rsp_next;
      end
   end

   clbm_slot_ram #(
      .DEPTH (CHANNELS),
      .IDX_W (IDX_W)
   ) u_slot_ram (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_idx  (chan_ext[IDX_W-1:0]),
      .rd_data (slot_rd),
      .wr_en   (exec_done && chan_valid_ff),
      .wr_idx  (chan_ext_q[IDX_W-1:0]),
      .wr_data (slot_wr)
   );

   clbm_update u_update (
      .req        (req_ff),
      .chan_valid (chan_valid_ff),
      .slot_rd    (slot_rd),
      .base       (base_eff),
      .max_delay  (max_eff),
      .slot_wr    (slot_wr),
      .rsp        (rsp_next)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a new result appears only after a transaction finished its update cycle
   a_rsp_from_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == clbm_pkg::CTL_EXEC))
      else $error("result raised without an update cycle");

   // accepted transaction always moves to the update cycle
   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == clbm_pkg::CTL_EXEC)
      else $error("accepted transaction did not reach update");

   // restart only reported for nosignal or fail
   a_restart_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.restart_request |->
         rsp_data_ff.status == clbm_pkg::ST_NOSIGNAL || rsp_data_ff.status == clbm_pkg::ST_FAIL)
      else $error("restart with wrong status");

   // online notification implies online status
   a_online_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.notify_online |-> rsp_data_ff.status == clbm_pkg::ST_ONLINE)
      else $error("online notify without online status");

   // an error result never carries a notification
   a_error_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.error |->
         !rsp_data_ff.notify_offline && !rsp_data_ff.notify_online)
      else $error("error result with notification");

endmodule
